// ----- src/teb_pkg.sv -----
// shared constants and types for the triangle edge test
package teb_pkg;

    localparam int VERT_W  = 24;
    localparam int PIX_W   = 12;
    localparam int SUB_W   = 8;
    localparam int WF      = 16;
    localparam int WW      = WF + 2;
    localparam int DIFF_W  = VERT_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int SUM_W   = AREA_W + 2;
    localparam int MAG_W   = SUM_W;
    localparam int REM_W   = MAG_W + 1;
    localparam int QB      = WF + 1;

    localparam logic [WW-1:0] THIRD   = WW'((1 << WF) / 3);
    localparam logic [WW-1:0] W_MAX   = WW'((1 << (WF + 1)) - 1);
    localparam logic [WW-1:0] W_MIN   = WW'(1 << (WF + 1));

    // word carried along the divider row; lane 0 is weight a, 1 is b, 2 is c
    typedef struct packed {
        logic                       vld;
        logic                       degen;
        logic                       in_tri;
        logic [MAG_W-1:0]           ns;
        logic [2:0]                 neg;
        logic [2:0]                 sat;
        logic [2:0][REM_W-1:0]      rem;
        logic [2:0][QB-1:0]         q;
    } teb_word_t;

endpackage

// ----- src/teb_area.sv -----
// edge function front end: differences, products, areas, sum, magnitudes
module teb_area (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [teb_pkg::VERT_W-1:0]    vert_a_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_a_y,
    input  logic [teb_pkg::VERT_W-1:0]    vert_b_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_b_y,
    input  logic [teb_pkg::VERT_W-1:0]    vert_c_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_c_y,
    input  logic [teb_pkg::PIX_W-1:0]     pixel_x,
    input  logic [teb_pkg::PIX_W-1:0]     pixel_y,
    output teb_pkg::teb_word_t            word
);
    import teb_pkg::*;

    logic [5:0] vld_reg;

    logic signed [DIFF_W-1:0] vx [3];
    logic signed [DIFF_W-1:0] vy [3];
    logic signed [DIFF_W-1:0] px;
    logic signed [DIFF_W-1:0] py;

    logic signed [DIFF_W-1:0] d_reg [3][4];
    logic signed [PROD_W-1:0] p_reg [3][2];
    logic signed [AREA_W-1:0] ar_reg [3];
    logic signed [AREA_W-1:0] ar4_reg [3];
    logic signed [SUM_W-1:0]  sum_reg;

    logic [REM_W-1:0]         na_reg [3];
    logic [MAG_W-1:0]         ns_reg;
    logic [2:0]               neg_reg;
    logic                     degen_reg;
    logic                     inside_reg;

    teb_word_t                word_reg;
    teb_word_t                word_next;

    logic signed [SUM_W-1:0]  sum_next;
    logic                     all_ge;
    logic                     all_le;

    always_comb
    begin
        vx[0] = DIFF_W'(signed'(vert_a_x));
        vy[0] = DIFF_W'(signed'(vert_a_y));
        vx[1] = DIFF_W'(signed'(vert_b_x));
        vy[1] = DIFF_W'(signed'(vert_b_y));
        vx[2] = DIFF_W'(signed'(vert_c_x));
        vy[2] = DIFF_W'(signed'(vert_c_y));
        px = signed'({{(DIFF_W - PIX_W - SUB_W){1'b0}}, pixel_x, {SUB_W{1'b0}}});
        py = signed'({{(DIFF_W - PIX_W - SUB_W){1'b0}}, pixel_y, {SUB_W{1'b0}}});
    end

    assign sum_next = SUM_W'(ar_reg[0]) + SUM_W'(ar_reg[1]) + SUM_W'(ar_reg[2]);
    assign all_ge = !ar4_reg[0][AREA_W-1] && !ar4_reg[1][AREA_W-1] && !ar4_reg[2][AREA_W-1];
    assign all_le = (ar4_reg[0][AREA_W-1] || ar4_reg[0] == '0)
                 && (ar4_reg[1][AREA_W-1] || ar4_reg[1] == '0)
                 && (ar4_reg[2][AREA_W-1] || ar4_reg[2] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edge e runs from vertex e to vertex e+1 (wrapping)
            for (int e = 0; e < 3; e++)
            begin
                d_reg[e][0] <= vx[(e + 1) % 3] - vx[e];
                d_reg[e][1] <= py - vy[e];
                d_reg[e][2] <= vy[(e + 1) % 3] - vy[e];
                d_reg[e][3] <= px - vx[e];
                p_reg[e][0] <= PROD_W'(d_reg[e][0] * d_reg[e][1]);
                p_reg[e][1] <= PROD_W'(d_reg[e][2] * d_reg[e][3]);
                ar_reg[e]   <= AREA_W'(p_reg[e][0]) - AREA_W'(p_reg[e][1]);
                ar4_reg[e]  <= ar_reg[e];
            end
            sum_reg <= sum_next;
            // weight a uses edge bc, b uses ca, c uses ab
            for (int i = 0; i < 3; i++)
            begin
                na_reg[i] <= ar4_reg[(i + 1) % 3][AREA_W-1]
                             ? REM_W'(-ar4_reg[(i + 1) % 3])
                             : REM_W'(ar4_reg[(i + 1) % 3]);
                neg_reg[i] <= ar4_reg[(i + 1) % 3][AREA_W-1] ^ sum_reg[SUM_W-1];
            end
            ns_reg     <= sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
            degen_reg  <= (sum_reg == '0);
            inside_reg <= (all_ge || all_le) && (sum_reg != '0);
            word_reg   <= word_next;
        end
    end

    always_comb
    begin
        word_next        = '0;
        word_next.vld    = vld_reg[4];
        word_next.degen  = degen_reg;
        word_next.in_tri = inside_reg;
        word_next.ns     = ns_reg;
        word_next.neg    = neg_reg;
        for (int i = 0; i < 3; i++)
        begin
            // integer part of two or more saturates
            word_next.sat[i] = na_reg[i] >= {ns_reg, 1'b0};
            word_next.rem[i] = na_reg[i];
        end
    end

    always_comb
    begin
        word     = word_reg;
        word.vld = vld_reg[5];
    end

endmodule

// ----- src/teb_div_cell.sv -----
// one restoring division cell: one quotient bit for each of the three lanes
module teb_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  teb_pkg::teb_word_t    word_in,
    output teb_pkg::teb_word_t    word_out
);
    import teb_pkg::*;

    teb_word_t        word_reg;
    teb_word_t        word_next;
    logic [REM_W-1:0] diff;
    logic             qbit;

    always_comb
    begin
        word_next = word_in;
        diff      = '0;
        qbit      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qbit = word_in.rem[i] >= {1'b0, word_in.ns};
            diff = qbit ? word_in.rem[i] - {1'b0, word_in.ns} : word_in.rem[i];
            word_next.rem[i] = {diff[REM_W-2:0], 1'b0};
            word_next.q[i]   = {word_in.q[i][QB-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// ----- src/triangle_edge_test_barycentric.sv -----
// top level of the pipelined point-in-triangle test with barycentric weights
//
// one input word carries three vertices (signed, 8 fractional bits) and an
// integer pixel; one output word carries inside_res, degenerate and the
// three weights in signed q2.16, truncated toward zero and saturated.
// both channels are valid/ready; a word moves when valid and ready are high.
// the block takes one word per cycle and returns one word per cycle unless the pipe stalls.
// from input accept to output valid a word passes through 6 front stages
// (differences, 25x25 products, areas, sum, magnitudes, range check), a row
// of 17 division cells each producing one quotient bit, and the output reg.
// the whole pipe advances together; when out_ready is low with a word
// waiting, every stage holds and in_ready drops, otherwise in_ready is high.
// reset clears all valid bits; no clearing pass is needed.
// a zero area sum reports degenerate with all weights one third.
module triangle_edge_test_barycentric (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [teb_pkg::VERT_W-1:0]    vert_a_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_a_y,
    input  logic [teb_pkg::VERT_W-1:0]    vert_b_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_b_y,
    input  logic [teb_pkg::VERT_W-1:0]    vert_c_x,
    input  logic [teb_pkg::VERT_W-1:0]    vert_c_y,
    input  logic [teb_pkg::PIX_W-1:0]     pixel_x,
    input  logic [teb_pkg::PIX_W-1:0]     pixel_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic                          degenerate,
    output logic [teb_pkg::WW-1:0]        bary_a,
    output logic [teb_pkg::WW-1:0]        bary_b,
    output logic [teb_pkg::WW-1:0]        bary_c
);
    import teb_pkg::*;

    // global advance: the output register is free or being drained
    logic             en;
    teb_word_t        chain [QB+1];

    logic             out_valid_reg;
    logic             inside_reg;
    logic             degen_reg;
    logic [WW-1:0]    w_reg [3];
    logic [WW-1:0]    w_next [3];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // front end: edge functions and divider operands
    teb_area u_area (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .vert_a_x (vert_a_x),
        .vert_a_y (vert_a_y),
        .vert_b_x (vert_b_x),
        .vert_b_y (vert_b_y),
        .vert_c_x (vert_c_x),
        .vert_c_y (vert_c_y),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .word     (chain[0])
    );

    // row of division cells, integer bit first then the fraction bits
    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        teb_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .word_in  (chain[k]),
            .word_out (chain[k+1])
        );
    end

    // sign, saturation and degenerate override
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (chain[QB].degen)
                w_next[i] = THIRD;
            else if (chain[QB].sat[i])
                w_next[i] = chain[QB].neg[i] ? W_MIN : W_MAX;
            else if (chain[QB].neg[i])
                w_next[i] = WW'(-{1'b0, chain[QB].q[i]});
            else
                w_next[i] = WW'({1'b0, chain[QB].q[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[QB].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= chain[QB].in_tri;
            degen_reg  <= chain[QB].degen;
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= w_next[i];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;
    assign bary_a     = w_reg[0];
    assign bary_b     = w_reg[1];
    assign bary_c     = w_reg[2];

`ifndef ASSERT_OFF
    a_degen_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(degenerate && inside_res))
        else $error("degenerate word flagged inside");

    a_degen_third: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            bary_a == THIRD && bary_b == THIRD && bary_c == THIRD)
        else $error("degenerate weights not one third");

    a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |->
            !bary_a[WW-1] && !bary_b[WW-1] && !bary_c[WW-1])
        else $error("inside pixel with negative weight");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain[QB].q[0]) && $stable(chain[0].vld))
        else $error("pipeline moved during stall");
`endif

endmodule
